### design/fiws_pkg.sv
// Shared types, constants and a helper function for the frame interval window statistics block.
package fiws_pkg;

    localparam int WIN    = 256;
    localparam int IDX_W  = 8;
    localparam int FILL_W = 9;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN);

    typedef struct packed {
        logic        op;
        logic [63:0] frame_seq;
        logic [63:0] present_time_ns;
        logic [31:0] refresh_period_ns;
        logic [31:0] frame_flags;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] out_seq;
        logic [63:0] out_present_ns;
        logic [31:0] out_refresh_ns;
        logic [31:0] out_flags;
        logic        interval_valid;
        logic [63:0] interval_ns;
        logic [31:0] presented_count;
        logic [31:0] discarded_count;
        logic [63:0] median_ns;
        logic [63:0] p95_ns;
        logic [63:0] max_ns;
    } t_out_beat;

    typedef struct packed {
        logic        go;
        logic        evict;
        logic        insert;
        logic [63:0] old_val;
        logic [63:0] new_val;
    } t_sort_cmd;

    typedef struct packed {
        logic              done;
        logic [FILL_W-1:0] fill;
        logic [63:0]       median;
        logic [63:0]       p95;
        logic [63:0]       max_v;
    } t_sort_rsp;

    typedef enum logic [2:0] {
        T_IDLE,
        T_RING,
        T_RWAIT,
        T_SORT,
        T_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RM,
        S_INS0,
        S_INS,
        S_PUT,
        S_ST,
        S_DONE
    } t_sort_state;

    localparam logic OP_PRESENT = 1'b0;
    localparam logic OP_DISCARD = 1'b1;

    // Zero-based index of rank ceil(95n/100), valid for 1 <= n <= WIN.
    function automatic logic [IDX_W-1:0] p95_index(input logic [FILL_W-1:0] fill);
        logic [14:0] x;
        logic [27:0] prod;
        logic [8:0]  r;
        x    = 15'(fill) * 15'd95 + 15'd99;
        prod = 28'(x) * 28'd5243;
        r    = prod[27:19];
        return IDX_W'(r - 9'd1);
    endfunction

endpackage

### design/fiws_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module fiws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/fiws_sort.sv
// Sorted window engine: removes, inserts and reads percentile ranks over a sorted RAM.
module fiws_sort import fiws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sort_cmd i_cmd,
    output t_sort_rsp o_rsp
);

    t_sort_state       r_state, n_state;
    logic [FILL_W-1:0] r_fill;
    logic [63:0]       r_old;
    logic [63:0]       r_new;
    logic              r_insert;
    logic [FILL_W-1:0] r_rd_idx;
    logic              r_chk_valid;
    logic [IDX_W-1:0]  r_chk_idx;
    logic              r_found;
    logic              r_issue_done;
    logic [1:0]        r_st_cnt;
    logic [63:0]       r_med;
    logic [63:0]       r_p95;
    logic [63:0]       r_max;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [63:0]       ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [63:0]       ram_rdata;

    logic              rm_issue;
    logic              rm_end;
    logic              ins_bigger;
    logic [IDX_W-1:0]  last_idx;

    assign rm_issue   = (r_rd_idx < r_fill);
    assign rm_end     = (r_rd_idx == r_fill) && !r_chk_valid;
    assign ins_bigger = (ram_rdata > r_new);
    assign last_idx   = IDX_W'(r_fill - FILL_W'(1));

    fiws_ram #(.WIDTH(64), .DEPTH(WIN)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.go) begin
                    if (i_cmd.evict) begin
                        n_state = S_RM;
                    end else if (i_cmd.insert) begin
                        n_state = S_INS0;
                    end else begin
                        n_state = S_ST;
                    end
                end
            end
            S_RM: begin
                if (rm_end) begin
                    n_state = r_insert ? S_INS0 : S_ST;
                end
            end
            S_INS0: begin
                n_state = (r_fill == '0) ? S_ST : S_INS;
            end
            S_INS: begin
                if (!ins_bigger) begin
                    n_state = S_ST;
                end else if (r_chk_idx == '0) begin
                    n_state = S_PUT;
                end
            end
            S_PUT:  n_state = S_ST;
            S_ST: begin
                if (r_fill == '0 || r_st_cnt == 2'd3) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = ram_rdata;
        ram_raddr = r_rd_idx[IDX_W-1:0];
        unique case (r_state)
            S_RM: begin
                if (r_chk_valid && r_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_idx - IDX_W'(1);
                end
            end
            S_INS0: begin
                ram_raddr = last_idx;
                if (r_fill == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = r_new;
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_chk_idx + IDX_W'(1);
                ram_wdata = ins_bigger ? ram_rdata : r_new;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_new;
            end
            S_ST: begin
                unique case (r_st_cnt)
                    2'd0:    ram_raddr = last_idx >> 1;
                    2'd1:    ram_raddr = p95_index(r_fill);
                    default: ram_raddr = last_idx;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_st_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != S_ST) begin
                r_st_cnt <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_old       <= i_cmd.old_val;
                    r_new       <= i_cmd.new_val;
                    r_insert    <= i_cmd.insert;
                    r_rd_idx    <= '0;
                    r_chk_valid <= 1'b0;
                    r_found     <= 1'b0;
                end
                S_RM: begin
                    if (rm_issue) begin
                        r_rd_idx    <= r_rd_idx + FILL_W'(1);
                        r_chk_idx   <= r_rd_idx[IDX_W-1:0];
                        r_chk_valid <= 1'b1;
                    end else begin
                        r_chk_valid <= 1'b0;
                    end
                    if (r_chk_valid && !r_found && ram_rdata == r_old) begin
                        r_found <= 1'b1;
                    end
                    if (rm_end) begin
                        r_fill <= r_fill - FILL_W'(r_found);
                    end
                end
                S_INS0: begin
                    if (r_fill == '0) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_chk_idx    <= last_idx;
                    r_rd_idx     <= r_fill - FILL_W'(2);
                    r_issue_done <= (r_fill == FILL_W'(1));
                end
                S_INS: begin
                    if (!r_issue_done) begin
                        r_chk_idx    <= r_rd_idx[IDX_W-1:0];
                        r_rd_idx     <= r_rd_idx - FILL_W'(1);
                        r_issue_done <= (r_rd_idx == '0);
                    end
                    if (!ins_bigger) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                end
                S_PUT: r_fill <= r_fill + FILL_W'(1);
                S_ST: begin
                    r_st_cnt <= r_st_cnt + 2'd1;
                    if (r_fill == '0) begin
                        r_med <= '0;
                        r_p95 <= '0;
                        r_max <= '0;
                    end else begin
                        unique case (r_st_cnt)
                            2'd1:    r_med <= ram_rdata;
                            2'd2:    r_p95 <= ram_rdata;
                            2'd3:    r_max <= ram_rdata;
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.fill   = r_fill;
    assign o_rsp.median = r_med;
    assign o_rsp.p95    = r_p95;
    assign o_rsp.max_v  = r_max;

endmodule

### design/frame_interval_window_stats_top.sv
// Top level of the frame interval window statistics block.
// Each input beat is a presented or a discarded frame; each yields one output beat.
// A presented frame after the first measures the wrapping interval from the previous
// timestamp and adds it to a window of the last 256 intervals, evicting the oldest.
// The output beat echoes a presented frame (zeros if discarded), gives the interval,
// saturating frame counts, and the nearest-rank median, 95th percentile and window max.
// One beat is processed at a time: o_in_stall is high from acceptance until the result
// is loaded into the output register, and the result beat is valid right after that.
// A frame with an interval keeps the input stalled longer than a beat without one, while
// the sorted RAM is walked for removal of the oldest interval on a full window and for
// insertion of the new one.
// The output register holds its beat while i_out_stall is high; a finished result waits
// there and the next input beat can be accepted meanwhile.
// Synchronous reset clears the counters, the last timestamp and the window; the RAM
// contents need no clearing.
module frame_interval_window_stats_top import fiws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_top_state       r_state, n_state;
    t_in_beat         r_item;
    logic             r_push;
    logic [63:0]      r_iv;
    logic [63:0]      r_last;
    logic             r_have;
    logic [31:0]      r_pres_cnt;
    logic [31:0]      r_disc_cnt;
    logic [IDX_W-1:0] r_oldest;
    logic             r_full;
    t_out_beat        r_out;
    logic             r_out_valid;

    t_sort_cmd        cmd;
    t_sort_rsp        rsp;
    logic             accept;
    logic             out_free;
    logic             ring_we;
    logic [IDX_W-1:0] ring_waddr;
    logic [63:0]      ring_rdata;

    assign o_in_stall = (r_state != T_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    fiws_ram #(.WIDTH(64), .DEPTH(WIN)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_iv),
        .i_raddr (r_oldest),
        .o_rdata (ring_rdata)
    );

    fiws_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:  n_state = accept ? T_RING : T_IDLE;
            T_RING:  n_state = r_push ? T_RWAIT : T_SORT;
            T_RWAIT: n_state = T_SORT;
            T_SORT:  n_state = rsp.done ? T_OUT : T_SORT;
            T_OUT:   n_state = out_free ? T_IDLE : T_OUT;
            default: n_state = T_IDLE;
        endcase
    end

    always_comb begin
        cmd.go      = 1'b0;
        cmd.evict   = 1'b0;
        cmd.insert  = 1'b0;
        cmd.old_val = ring_rdata;
        cmd.new_val = r_iv;
        ring_we     = 1'b0;
        ring_waddr  = r_full ? r_oldest : r_oldest + rsp.fill[IDX_W-1:0];
        unique case (r_state)
            T_RING: begin
                cmd.go = !r_push;
            end
            T_RWAIT: begin
                cmd.go     = 1'b1;
                cmd.evict  = r_full;
                cmd.insert = 1'b1;
                ring_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_last      <= '0;
            r_have      <= 1'b0;
            r_pres_cnt  <= '0;
            r_disc_cnt  <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == T_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_item <= i_in_data;
                        if (i_in_data.op == OP_PRESENT) begin
                            r_push <= r_have;
                            r_iv   <= i_in_data.present_time_ns - r_last;
                            r_last <= i_in_data.present_time_ns;
                            r_have <= 1'b1;
                            if (r_pres_cnt != '1) begin
                                r_pres_cnt <= r_pres_cnt + 32'd1;
                            end
                        end else begin
                            r_push <= 1'b0;
                            if (r_disc_cnt != '1) begin
                                r_disc_cnt <= r_disc_cnt + 32'd1;
                            end
                        end
                    end
                end
                T_RING: r_full <= (rsp.fill == FILL_FULL);
                T_RWAIT: begin
                    if (r_full) begin
                        r_oldest <= r_oldest + IDX_W'(1);
                    end
                end
                T_OUT: begin
                    if (out_free) begin
                        if (r_item.op == OP_PRESENT) begin
                            r_out.out_seq        <= r_item.frame_seq;
                            r_out.out_present_ns <= r_item.present_time_ns;
                            r_out.out_refresh_ns <= r_item.refresh_period_ns;
                            r_out.out_flags      <= r_item.frame_flags;
                        end else begin
                            r_out.out_seq        <= '0;
                            r_out.out_present_ns <= '0;
                            r_out.out_refresh_ns <= '0;
                            r_out.out_flags      <= '0;
                        end
                        r_out.interval_valid  <= r_push;
                        r_out.interval_ns     <= r_push ? r_iv : '0;
                        r_out.presented_count <= r_pres_cnt;
                        r_out.discarded_count <= r_disc_cnt;
                        r_out.median_ns       <= rsp.median;
                        r_out.p95_ns          <= rsp.p95;
                        r_out.max_ns          <= rsp.max_v;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
